@@ src/wmda_pkg.sv @@
// ----------------------------------------------------------------------------
// Window mean versus decaying average: shared definitions
// Types, constants and codes used by the controller, datapath and checker.
// ----------------------------------------------------------------------------
package wmda_pkg;

  localparam int WINDOW_MAX_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 20;

  localparam int LEN_W   = 11;  // window_len register
  localparam int INV_W   = 33;  // Q1.32 reciprocals
  localparam int MEAN_W  = 36;  // Q20.16 means
  localparam int ERR_W   = 24;  // Q8.16 relative error
  localparam int DECAY_W = 44;  // Q20.24 decaying average
  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + INV_W;     // 65
  localparam int ACC_W   = PROD_W - 8 + 1;      // decay + sample term
  localparam int UPD_W   = ACC_W + 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [DECAY_W-1:0] DECAY_MAX = {DECAY_W{1'b1}};
  localparam logic [MEAN_W-1:0]  MEAN_MAX  = {MEAN_W{1'b1}};
  localparam logic [ERR_W-1:0]   ERR_MAX   = {ERR_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_INV_WINDOW = 2'd1,
    CFG_INV_DECAY  = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TERM,
    ST_ACC,
    ST_MLO,
    ST_MHI,
    ST_UPD,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_ERR_GO,
    ST_ERR_WAIT,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_TERM,
    MUL_LO,
    MUL_HI
  } mul_op_e;

  typedef enum logic {
    DIV_MEAN,
    DIV_ERR
  } div_op_e;

  typedef struct packed {
    logic    accept;
    logic    upd_sum;
    logic    load_prod;
    mul_op_e mul_op;
    logic    load_acc;
    logic    load_lo;
    logic    load_decay;
    logic    div_start;
    div_op_e div_op;
    logic    load_mean;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic report;
    logic div_done;
    logic mean_zero;
    logic out_free;
  } status_t;

endpackage

@@ src/wmda_div.sv @@
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned long division, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module wmda_div import wmda_pkg::*; #(
  parameter int NUM_W = 52,
  parameter int DEN_W = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, num_q[NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d = cnt_q;
    num_d = num_q;
    rem_d = rem_q;
    if (start_i) begin
      cnt_d = CNT_W'(NUM_W);
      num_d = num_i;
      rem_d = '0;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
      // The shifted numerator slowly fills with quotient bits from the right.
      num_d = {num_q[NUM_W-2:0], ge};
      rem_d = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = (cnt_q == '0);
  assign quot_o = num_q;

endmodule

@@ src/wmda_dp.sv @@
// ----------------------------------------------------------------------------
// Window mean versus decaying average: datapath
// Delay line memory, running sum, shared multiplier, decay register,
// divider and the output register.
// ----------------------------------------------------------------------------
module wmda_dp import wmda_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   report_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [INV_W-1:0]       cfg_data_i,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic [MEAN_W-1:0]      window_mean_o,
  output logic [MEAN_W-1:0]      decay_mean_o,
  output logic [ERR_W-1:0]       rel_error_o,
  output logic                   error_flag_o
);

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SW = SAMPLE_BITS + LW;
  localparam int NW = (SW + 16 > MEAN_W + 16) ? SW + 16 : MEAN_W + 16;

  // Configuration registers
  logic [LEN_W-1:0] win_len_q;
  logic [INV_W-1:0] inv_win_q, inv_dec_q;
  logic             len_wr;

  assign len_wr = cfg_we_i && (cfg_idx_e'(cfg_index_i) == CFG_WINDOW_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= LEN_W'(1);
      inv_win_q <= {1'b1, {(INV_W-1){1'b0}}};
      inv_dec_q <= {1'b1, {(INV_W-1){1'b0}}};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_WINDOW_LEN: win_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_INV_WINDOW: inv_win_q <= cfg_data_i;
        CFG_INV_DECAY:  inv_dec_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective length and delay line addressing
  logic [31:0]      wl_ext, len_ext, wp_ext, old_ext;
  logic [LW-1:0]    eff_len;
  logic [AW-1:0]    old_idx;
  logic [AW-1:0]    wp_q;
  logic [LW-1:0]    fill_q;
  logic [SW-1:0]    sum_q;

  assign wl_ext = 32'(win_len_q);
  always_comb begin
    if (wl_ext == 32'd0) begin
      len_ext = 32'd1;
    end else if (wl_ext > 32'(WINDOW_MAX)) begin
      len_ext = 32'(WINDOW_MAX);
    end else begin
      len_ext = wl_ext;
    end
  end
  assign eff_len = len_ext[LW-1:0];

  assign wp_ext  = 32'(wp_q);
  assign old_ext = (wp_ext >= len_ext) ? wp_ext - len_ext
                                       : wp_ext + 32'(WINDOW_MAX) - len_ext;
  assign old_idx = old_ext[AW-1:0];

  // Slots are written in order from zero after a clear, so the outgoing slot
  // holds real data only once the fill count has reached the length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (len_wr) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.accept) begin
      wp_q <= (wp_ext == 32'(WINDOW_MAX - 1)) ? '0 : wp_q + AW'(1);
      if (32'(fill_q) != 32'(WINDOW_MAX)) begin
        fill_q <= fill_q + LW'(1);
      end
    end
  end

  logic [SAMPLE_BITS-1:0] mem_q [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0] old_q;
  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   report_q;
  logic                   old_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[wp_q] <= sample_i;
      old_q       <= mem_q[old_idx];
      sample_q    <= sample_i;
      report_q    <= report_i;
      old_valid_q <= 32'(fill_q) >= len_ext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (len_wr) begin
      sum_q <= '0;
    end else if (cmd_i.upd_sum) begin
      sum_q <= sum_q + SW'(sample_q) - (old_valid_q ? SW'(old_q) : SW'(0));
    end
  end

  // Shared multiplier and decay recurrence
  logic [MUL_A_W-1:0] mul_a;
  logic [INV_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p, prod_q;
  logic [ACC_W-1:0]   acc_q;
  logic [MUL_A_W-1:0] lo_q;
  logic [DECAY_W-1:0] decay_q;
  logic [UPD_W-1:0]   upd_sum;

  always_comb begin
    case (cmd_i.mul_op)
      MUL_TERM: begin
        mul_a = MUL_A_W'(sample_q);
        mul_b = inv_win_q;
      end
      MUL_LO: begin
        mul_a = acc_q[MUL_A_W-1:0];
        mul_b = {1'b0, inv_dec_q[INV_W-2:0]};
      end
      MUL_HI: begin
        mul_a = MUL_A_W'(acc_q[ACC_W-1:MUL_A_W]);
        mul_b = {1'b0, inv_dec_q[INV_W-2:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {{INV_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // The integer bit of the reciprocal adds the accumulator itself.
  assign upd_sum = (inv_dec_q[INV_W-1] ? UPD_W'(acc_q) : UPD_W'(0))
                 + UPD_W'(prod_q[ACC_W-1:0]) + UPD_W'(lo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_prod) begin
      prod_q <= mul_p;
    end
    if (cmd_i.load_lo) begin
      lo_q <= prod_q[2*MUL_A_W-1:MUL_A_W];
    end
    if (cmd_i.load_acc) begin
      acc_q <= ACC_W'(decay_q) + ACC_W'(prod_q[PROD_W-1:8]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= '0;
    end else if (cmd_i.load_decay) begin
      decay_q <= (upd_sum > UPD_W'(DECAY_MAX)) ? DECAY_MAX : upd_sum[DECAY_W-1:0];
    end
  end

  // Divisions for the window mean and the relative error
  logic [MEAN_W-1:0] mean_q, dmean, diff;
  logic [NW-1:0]     div_num, quot;
  logic [MEAN_W-1:0] div_den;
  logic              div_done;

  assign dmean = decay_q[DECAY_W-1:DECAY_W-MEAN_W];
  assign diff  = (mean_q > dmean) ? mean_q - dmean : dmean - mean_q;

  always_comb begin
    case (cmd_i.div_op)
      DIV_MEAN: begin
        div_num = NW'({sum_q, 16'd0});
        div_den = MEAN_W'(eff_len);
      end
      DIV_ERR: begin
        div_num = NW'({diff, 16'd0});
        div_den = mean_q;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  wmda_div #(
    .NUM_W (NW),
    .DEN_W (MEAN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_mean) begin
      mean_q <= (|quot[NW-1:MEAN_W]) ? MEAN_MAX : quot[MEAN_W-1:0];
    end
  end

  // Output register
  logic              out_valid_q;
  logic [MEAN_W-1:0] out_mean_q, out_dmean_q;
  logic [ERR_W-1:0]  out_err_q;
  logic              out_flag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mean_q  <= mean_q;
      out_dmean_q <= dmean;
      if (mean_q == '0) begin
        out_err_q  <= ERR_MAX;
        out_flag_q <= 1'b1;
      end else if (|quot[NW-1:ERR_W]) begin
        out_err_q  <= ERR_MAX;
        out_flag_q <= 1'b1;
      end else begin
        out_err_q  <= quot[ERR_W-1:0];
        out_flag_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign window_mean_o = out_mean_q;
  assign decay_mean_o  = out_dmean_q;
  assign rel_error_o   = out_err_q;
  assign error_flag_o  = out_flag_q;

  assign status_o.report    = report_q;
  assign status_o.div_done  = div_done;
  assign status_o.mean_zero = (mean_q == '0);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

@@ src/wmda_ctrl.sv @@
// ----------------------------------------------------------------------------
// Window mean versus decaying average: controller
// Sequences the multiply steps of the decay update and, for report items,
// the mean division, the error division unless the mean is zero, and the
// hand-over to the output register.
module wmda_ctrl import wmda_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_TERM;
      ST_TERM:      state_d = ST_ACC;
      ST_ACC:       state_d = ST_MLO;
      ST_MLO:       state_d = ST_MHI;
      ST_MHI:       state_d = ST_UPD;
      ST_UPD:       state_d = status_i.report ? ST_MEAN_GO : ST_IDLE;
      ST_MEAN_GO:   state_d = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (status_i.div_done) state_d = ST_ERR_GO;
      ST_ERR_GO:    state_d = status_i.mean_zero ? ST_FIN : ST_ERR_WAIT;
      ST_ERR_WAIT:  if (status_i.div_done) state_d = ST_FIN;
      ST_FIN:       if (status_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = MUL_TERM;
    cmd_o.div_op = DIV_MEAN;
    case (state_q)
      ST_IDLE: cmd_o.accept = in_valid_i;
      ST_TERM: begin
        cmd_o.upd_sum   = 1'b1;
        cmd_o.load_prod = 1'b1;
        cmd_o.mul_op    = MUL_TERM;
      end
      ST_ACC: cmd_o.load_acc = 1'b1;
      ST_MLO: begin
        cmd_o.load_prod = 1'b1;
        cmd_o.mul_op    = MUL_LO;
      end
      ST_MHI: begin
        cmd_o.load_prod = 1'b1;
        cmd_o.load_lo   = 1'b1;
        cmd_o.mul_op    = MUL_HI;
      end
      ST_UPD: cmd_o.load_decay = 1'b1;
      ST_MEAN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_MEAN;
      end
      ST_MEAN_WAIT: cmd_o.load_mean = status_i.div_done;
      ST_ERR_GO: begin
        // A zero mean needs no division: the error saturates.
        cmd_o.div_start = !status_i.mean_zero;
        cmd_o.div_op    = DIV_ERR;
      end
      ST_ERR_WAIT: cmd_o.div_op = DIV_ERR;
      ST_FIN: cmd_o.load_out = status_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

@@ src/window_mean_vs_decay_average_unit.sv @@
// ----------------------------------------------------------------------------
// Window mean versus decaying average unit
// Keeps a delay line of recent samples with a running sum and a decaying
// average, and on request reports the exact mean, the average and their
// relative error.
// ----------------------------------------------------------------------------
// One sample is taken at a time. For an item without report, the decay
// update runs three products in series through one shared 32x33 multiplier
// before the next transfer. A report item adds the division for the mean
// and, unless the mean is zero, the division for the error, on a divider
// that yields one quotient bit per cycle. The finished result sits in
// an output register, so the next sample is taken while it waits. Writing
// window_len empties the window at once through a fill count; no clearing
// pass is needed. Configuration writes are always ready.
module window_mean_vs_decay_average_unit import wmda_pkg::*; #(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  logic                   report_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [MEAN_W-1:0]      window_mean_o,
  output logic [MEAN_W-1:0]      decay_mean_o,
  output logic [ERR_W-1:0]       rel_error_o,
  output logic                   error_flag_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [INV_W-1:0]       cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  wmda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmda_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i      (sample_i),
    .report_i      (report_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .window_mean_o (window_mean_o),
    .decay_mean_o  (decay_mean_o),
    .rel_error_o   (rel_error_o),
    .error_flag_o  (error_flag_o)
  );

endmodule

@@ src/wmda_checker.sv @@
// ----------------------------------------------------------------------------
// Window mean versus decaying average: port checker
// Watches the top-level ports and flags behaviour the unit must never show.
// ----------------------------------------------------------------------------
module wmda_checker import wmda_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input logic [SAMPLE_BITS-1:0] sample_i,
  input logic                   report_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [MEAN_W-1:0]      window_mean_o,
  input logic [MEAN_W-1:0]      decay_mean_o,
  input logic [ERR_W-1:0]       rel_error_o,
  input logic                   error_flag_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o,
  input logic [CFG_IDX_W-1:0]   cfg_index_i,
  input logic [INV_W-1:0]       cfg_data_i
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its window mean and relative error.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(window_mean_o) && $stable(rel_error_o))
    else $error("result changed while stalled");

  // Every sample needs more work before the next transfer: no two are taken back to back.
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second sample taken back to back");

  // A zero mean must always raise the flag.
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_mean_o == '0 |-> error_flag_o)
    else $error("zero mean without flag");

  // The flag always comes with a saturated error.
  a_flag_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_flag_o |-> rel_error_o == ERR_MAX)
    else $error("flag without saturated error");

endmodule

bind window_mean_vs_decay_average_unit wmda_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_wmda_checker (.*);
